>>> src/flah_pkg.sv
// Types, constants and helper functions shared by the four-lane ARX hash.
// No dependencies; flah_datapath, flah_ctrl, the top level and the testbench refer to it by scoped names.
`timescale 1ns / 1ps

package flah_pkg;

    // Request codes carried in req_type
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_DATA  = 1'b1;

    // Seeding and finaliser multipliers
    localparam logic [63:0] PHI = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MX1 = 64'h85EBCA77C2B2AE3D;
    localparam logic [63:0] MX2 = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MX3 = 64'h94D049BB133111EB;

    // Lane rotations
    localparam int unsigned ROT_ONE   = 11;
    localparam int unsigned ROT_TWO   = 17;
    localparam int unsigned ROT_THREE = 23;
    localparam int unsigned ROT_FOUR  = 57;

    // Finaliser xorshift amounts
    localparam int unsigned FOLD_SHIFT  = 29;
    localparam int unsigned FIN_SHIFT_A = 31;
    localparam int unsigned FIN_SHIFT_B = 37;
    localparam int unsigned FIN_SHIFT_C = 41;

    // Last lane index and last finaliser round
    localparam logic [1:0] LAST_LANE  = 2'd3;
    localparam logic [1:0] LAST_ROUND = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LEN_GO,
        S_LEN_WAIT,
        S_SEED_GO,
        S_SEED_WAIT,
        S_FOLD,
        S_FIN_GO,
        S_FIN_WAIT,
        S_LOAD
    } flah_state_t;

    // Operand selection for the shared multiplier
    typedef enum logic [1:0] {
        MSEL_LEN,
        MSEL_BASE,
        MSEL_FIN
    } flah_msel_t;

    // Destination of a finished product
    typedef enum logic [1:0] {
        WB_NONE,
        WB_BASE,
        WB_LANE,
        WB_FIN
    } flah_wb_t;

    typedef struct packed {
        logic       start;
        logic       data;
        logic       mul_go;
        flah_msel_t msel;
        logic [1:0] idx;
        flah_wb_t   wb;
        logic       fold;
        logic       load;
    } flah_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic last_word;
        logic len_zero;
    } flah_sts_t;

    function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned k);
        return (x << k) | (x >> (64 - k));
    endfunction

    function automatic logic [63:0] seed_const(input logic [1:0] idx);
        logic [63:0] c;
        case (idx)
            2'd0:    c = PHI;
            2'd1:    c = MX1;
            2'd2:    c = MX2;
            default: c = MX3;
        endcase
        return c;
    endfunction

    function automatic logic [63:0] fin_const(input logic [1:0] idx);
        logic [63:0] c;
        case (idx)
            2'd0:    c = MX1;
            2'd1:    c = MX2;
            default: c = PHI;
        endcase
        return c;
    endfunction

    function automatic logic [63:0] fin_mix(input logic [63:0] x, input logic [1:0] idx);
        logic [63:0] r;
        case (idx)
            2'd0:    r = x ^ (x >> FIN_SHIFT_A);
            2'd1:    r = x ^ (x >> FIN_SHIFT_B);
            default: r = x ^ (x >> FIN_SHIFT_C);
        endcase
        return r;
    endfunction

    // Keep the first n bytes of a word, n from 0 to 7
    function automatic logic [63:0] tail_mask(input logic [2:0] n);
        logic [63:0] m;
        for (int i = 0; i < 8; i++)
        begin
            m[8*i +: 8] = (3'(i) < n) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

>>> src/flah_in_if.sv
// Request channel of the hash block: valid/ready with start and data fields.
// Depends on nothing.
`timescale 1ns / 1ps

interface flah_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [63:0] seed;
    logic [31:0] total_length;
    logic [63:0] data_word;

    modport source (output valid, req_type, seed, total_length, data_word, input ready);
    modport sink   (input valid, req_type, seed, total_length, data_word, output ready);
endinterface

>>> src/flah_out_if.sv
// Result channel of the hash block: valid/ready with the digest.
// Depends on nothing.
`timescale 1ns / 1ps

interface flah_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest;

    modport source (output valid, digest, input ready);
    modport sink   (input valid, digest, output ready);
endinterface

>>> src/flah_mul.sv
// Low 64 bits of a 64 x 64 product, built from three partial products on one 32 x 32 multiplier.
// Depends on nothing; used by flah_datapath.
`timescale 1ns / 1ps

module flah_mul
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] p
);

    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [1:0]  phase_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] prod_reg;
    logic [63:0] acc_reg;
    logic [63:0] p_reg;
    logic [31:0] op_x;
    logic [31:0] op_y;
    logic [63:0] mult;

    // Pick the partial product for this phase: low*low, low*high, high*low
    always_comb
    begin
        case (phase_reg)
            2'd0:
            begin
                op_x = a_reg[31:0];
                op_y = b_reg[31:0];
            end
            2'd1:
            begin
                op_x = a_reg[31:0];
                op_y = b_reg[63:32];
            end
            default:
            begin
                op_x = a_reg[63:32];
                op_y = b_reg[31:0];
            end
        endcase
    end

    assign mult = 64'(op_x) * 64'(op_y);

    // Sequence the control bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                phase_reg <= 2'd0;
                busy_reg  <= 1'b1;
            end
            else if (busy_reg)
            begin
                phase_reg <= phase_reg + 2'd1;
                if (phase_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Accumulate the partial products; cross terms only touch the upper half
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        else if (busy_reg)
        begin
            prod_reg <= mult;
            case (phase_reg)
                2'd1:    acc_reg <= prod_reg;
                2'd2:    acc_reg[63:32] <= acc_reg[63:32] + prod_reg[31:0];
                2'd3:    p_reg <= {acc_reg[63:32] + prod_reg[31:0], acc_reg[31:0]};
                default: ;
            endcase
        end
    end

    assign done = done_reg;
    assign p    = p_reg;

endmodule

>>> src/flah_datapath.sv
// Lanes, byte counter, seeding and finaliser registers of the hash block.
// Depends on flah_pkg and flah_mul; driven by flah_ctrl through a command struct.
`timescale 1ns / 1ps

module flah_datapath
#(
    parameter int LEN_BITS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  flah_pkg::flah_cmd_t cmd,
    input  logic [63:0]        seed,
    input  logic [31:0]        total_length,
    input  logic [63:0]        data_word,
    output flah_pkg::flah_sts_t sts,
    output logic [63:0]        digest
);

    // Length bits that survive the 32-bit field
    localparam int LW = (LEN_BITS < 32) ? LEN_BITS : 32;
    localparam logic [LW-1:0] WORD_BYTES  = LW'(8);
    localparam logic [LW-1:0] BLOCK_BYTES = LW'(32);

    logic [63:0]   lane_one_reg, lane_one_next;
    logic [63:0]   lane_two_reg, lane_two_next;
    logic [63:0]   lane_three_reg, lane_three_next;
    logic [63:0]   lane_four_reg, lane_four_next;
    logic [LW-1:0] rem_reg, rem_next;
    logic [1:0]    slot_reg, slot_next;
    logic          active_reg, active_next;
    logic [63:0]   seed_reg, seed_next;
    logic [63:0]   base_reg, base_next;
    logic [63:0]   h_reg, h_next;
    logic [63:0]   digest_reg, digest_next;

    logic [63:0]   mul_a;
    logic [63:0]   mul_b;
    logic          mul_done;
    logic [63:0]   mul_p;
    logic [63:0]   folded;
    logic          in_block;

    flah_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (cmd.mul_go),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    // Select multiplier operands; the length still sits in the byte counter
    always_comb
    begin
        case (cmd.msel)
            flah_pkg::MSEL_LEN:
            begin
                mul_a = 64'(rem_reg);
                mul_b = flah_pkg::PHI;
            end
            flah_pkg::MSEL_BASE:
            begin
                mul_a = base_reg;
                mul_b = flah_pkg::seed_const(cmd.idx);
            end
            default:
            begin
                mul_a = h_reg;
                mul_b = flah_pkg::fin_const(cmd.idx);
            end
        endcase
    end

    assign in_block = (slot_reg != 2'd0) || (rem_reg >= BLOCK_BYTES);
    assign folded   = lane_one_reg ^ lane_two_reg ^ lane_three_reg ^ lane_four_reg;

    // Work out the next register values for each command
    always_comb
    begin
        lane_one_next   = lane_one_reg;
        lane_two_next   = lane_two_reg;
        lane_three_next = lane_three_reg;
        lane_four_next  = lane_four_reg;
        rem_next        = rem_reg;
        slot_next       = slot_reg;
        active_next     = active_reg;
        seed_next       = seed_reg;
        base_next       = base_reg;
        h_next          = h_reg;
        digest_next     = digest_reg;

        // Open a message
        if (cmd.start)
        begin
            seed_next   = seed;
            rem_next    = total_length[LW-1:0];
            slot_next   = 2'd0;
            active_next = (total_length[LW-1:0] != '0);
        end

        // Mix a data word into the lanes
        if (cmd.data && active_reg)
        begin
            if (in_block)
            begin
                case (slot_reg)
                    2'd0:
                        lane_one_next = flah_pkg::rotl((lane_one_reg ^ data_word)
                            + lane_two_reg, flah_pkg::ROT_ONE);
                    2'd1:
                        lane_two_next = flah_pkg::rotl((lane_two_reg ^ data_word)
                            + lane_three_reg, flah_pkg::ROT_TWO);
                    2'd2:
                        lane_three_next = flah_pkg::rotl((lane_three_reg ^ data_word)
                            + lane_four_reg, flah_pkg::ROT_THREE);
                    default:
                        lane_four_next = flah_pkg::rotl((lane_four_reg ^ data_word)
                            + lane_one_reg, flah_pkg::ROT_FOUR);
                endcase
                slot_next = slot_reg + 2'd1;
                rem_next  = rem_reg - WORD_BYTES;
            end
            else if (rem_reg >= WORD_BYTES)
            begin
                lane_one_next = flah_pkg::rotl((lane_one_reg ^ data_word)
                    + lane_two_reg, flah_pkg::ROT_ONE);
                rem_next = rem_reg - WORD_BYTES;
            end
            else
            begin
                // Partial tail word, padded with zero bytes
                lane_one_next = flah_pkg::rotl((lane_one_reg
                    ^ (data_word & flah_pkg::tail_mask(rem_reg[2:0])))
                    + lane_two_reg, flah_pkg::ROT_ONE);
                rem_next = '0;
            end

            if (rem_next == '0)
            begin
                active_next = 1'b0;
                slot_next   = 2'd0;
            end
        end

        // Write back a finished product
        case (cmd.wb)
            flah_pkg::WB_BASE:
                base_next = seed_reg ^ mul_p;
            flah_pkg::WB_LANE:
                case (cmd.idx)
                    2'd0:    lane_one_next   = mul_p;
                    2'd1:    lane_two_next   = mul_p;
                    2'd2:    lane_three_next = mul_p;
                    default: lane_four_next  = mul_p;
                endcase
            flah_pkg::WB_FIN:
                h_next = flah_pkg::fin_mix(mul_p, cmd.idx);
            default: ;
        endcase

        // Fold the lanes into the finaliser word
        if (cmd.fold)
        begin
            h_next = folded ^ (folded >> flah_pkg::FOLD_SHIFT);
        end

        if (cmd.load)
        begin
            digest_next = h_reg;
        end
    end

    // Hold message state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_one_reg   <= '0;
            lane_two_reg   <= '0;
            lane_three_reg <= '0;
            lane_four_reg  <= '0;
            rem_reg        <= '0;
            slot_reg       <= 2'd0;
            active_reg     <= 1'b0;
        end
        else
        begin
            lane_one_reg   <= lane_one_next;
            lane_two_reg   <= lane_two_next;
            lane_three_reg <= lane_three_next;
            lane_four_reg  <= lane_four_next;
            rem_reg        <= rem_next;
            slot_reg       <= slot_next;
            active_reg     <= active_next;
        end
    end

    // Hold payload words
    always_ff @(posedge clk)
    begin
        seed_reg   <= seed_next;
        base_reg   <= base_next;
        h_reg      <= h_next;
        digest_reg <= digest_next;
    end

    assign sts.mul_done  = mul_done;
    assign sts.last_word = active_reg && (rem_reg <= WORD_BYTES);
    assign sts.len_zero  = (rem_reg == '0);
    assign digest        = digest_reg;

endmodule

>>> src/flah_ctrl.sv
// Controller of the hash block: handshakes, seeding and finaliser sequence.
// Depends on flah_pkg; issues commands to flah_datapath.
`timescale 1ns / 1ps

module flah_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_req_type,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  flah_pkg::flah_sts_t sts,
    output flah_pkg::flah_cmd_t cmd
);

    flah_pkg::flah_state_t state_reg, state_next;
    logic [1:0]            idx_reg, idx_next;
    logic                  out_valid_reg, out_valid_next;

    // Hold state, step counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= flah_pkg::S_IDLE;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.msel       = flah_pkg::MSEL_LEN;
        cmd.wb         = flah_pkg::WB_NONE;
        cmd.idx        = idx_reg;

        unique case (state_reg)
            flah_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_req_type == flah_pkg::REQ_START)
                    begin
                        cmd.start  = 1'b1;
                        state_next = flah_pkg::S_LEN_GO;
                    end
                    else
                    begin
                        cmd.data = 1'b1;
                        if (sts.last_word)
                        begin
                            state_next = flah_pkg::S_FOLD;
                        end
                    end
                end
            end
            flah_pkg::S_LEN_GO:
            begin
                cmd.mul_go = 1'b1;
                cmd.msel   = flah_pkg::MSEL_LEN;
                state_next = flah_pkg::S_LEN_WAIT;
            end
            flah_pkg::S_LEN_WAIT:
            begin
                if (sts.mul_done)
                begin
                    cmd.wb     = flah_pkg::WB_BASE;
                    idx_next   = 2'd0;
                    state_next = flah_pkg::S_SEED_GO;
                end
            end
            flah_pkg::S_SEED_GO:
            begin
                cmd.mul_go = 1'b1;
                cmd.msel   = flah_pkg::MSEL_BASE;
                state_next = flah_pkg::S_SEED_WAIT;
            end
            flah_pkg::S_SEED_WAIT:
            begin
                cmd.msel = flah_pkg::MSEL_BASE;
                if (sts.mul_done)
                begin
                    cmd.wb = flah_pkg::WB_LANE;
                    if (idx_reg == flah_pkg::LAST_LANE)
                    begin
                        state_next = sts.len_zero ? flah_pkg::S_FOLD : flah_pkg::S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = flah_pkg::S_SEED_GO;
                    end
                end
            end
            flah_pkg::S_FOLD:
            begin
                cmd.fold   = 1'b1;
                idx_next   = 2'd0;
                state_next = flah_pkg::S_FIN_GO;
            end
            flah_pkg::S_FIN_GO:
            begin
                cmd.mul_go = 1'b1;
                cmd.msel   = flah_pkg::MSEL_FIN;
                state_next = flah_pkg::S_FIN_WAIT;
            end
            flah_pkg::S_FIN_WAIT:
            begin
                cmd.msel = flah_pkg::MSEL_FIN;
                if (sts.mul_done)
                begin
                    cmd.wb = flah_pkg::WB_FIN;
                    if (idx_reg == flah_pkg::LAST_ROUND)
                    begin
                        state_next = flah_pkg::S_LOAD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = flah_pkg::S_FIN_GO;
                    end
                end
            end
            flah_pkg::S_LOAD:
            begin
                // Wait for the output register to drain
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = flah_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = flah_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

>>> src/four_lane_arx_hash.sv
// Top level of the streaming four-lane ARX hash.
// Depends on flah_pkg, flah_in_if, flah_out_if, flah_ctrl and flah_datapath.
`timescale 1ns / 1ps

// A data item is taken whenever the block is idle, so a message streams at one
// 64-bit word per clock. A start item occupies the block while the length product
// and the four lane seeds are formed: five 64-bit products, each built from
// partial products on one shared 32 x 32 multiplier, with an issue and a
// write-back state around it. After the item that ends a message, or after the
// seeding of a zero-length message, the lane fold and three finaliser products
// run before the digest enters the output register. The digest waits there
// until it is taken while the block goes on accepting items; a second digest
// waits inside the block until the first one has gone. Data items while no
// message is open are accepted and dropped.
module four_lane_arx_hash
#(
    parameter int LEN_BITS = 32
)
(
    input  logic            clk,
    input  logic            rst_n,
    flah_in_if.sink         request,
    flah_out_if.source      result
);

    flah_pkg::flah_cmd_t cmd;
    flah_pkg::flah_sts_t sts;

    flah_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (request.valid),
        .in_req_type (request.req_type),
        .in_ready    (request.ready),
        .out_valid   (result.valid),
        .out_ready   (result.ready),
        .sts         (sts),
        .cmd         (cmd)
    );

    flah_datapath #(.LEN_BITS(LEN_BITS)) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .seed         (request.seed),
        .total_length (request.total_length),
        .data_word    (request.data_word),
        .sts          (sts),
        .digest       (result.digest)
    );

    // Never overwrite a digest that is still waiting
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!result.valid || result.ready))
        else $error("digest loaded over a waiting result");

    // Every finished product is written somewhere
    a_mul_used: assert property (@(posedge clk) disable iff (!rst_n)
        sts.mul_done |-> (cmd.wb != flah_pkg::WB_NONE))
        else $error("multiplier result dropped");

    // A start item stalls the request channel while seeding
    a_start_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> !request.ready)
        else $error("item accepted during seeding");

    // The last word of a message leads into the finaliser
    a_last_word: assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready && (request.req_type == flah_pkg::REQ_DATA)
            && sts.last_word) |=> (!request.ready && cmd.fold))
        else $error("finaliser not started after last word");

endmodule

>>> dv/four_lane_arx_hash_tb.sv
// Self-checking testbench for the four-lane ARX hash: streams start and data items,
// predicts each digest and compares it with what the block delivers.
// Depends on flah_pkg, flah_in_if, flah_out_if and four_lane_arx_hash.
`timescale 1ns / 1ps

module four_lane_arx_hash_tb;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 10;
    localparam int QUIET_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 100;
    localparam int PRESS_HOLD   = 600;

    // Seeding and finaliser multipliers
    localparam logic [63:0] GOLD  = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_A = 64'h85EBCA77C2B2AE3D;
    localparam logic [63:0] MIX_B = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_C = 64'h94D049BB133111EB;
    localparam logic [3:0][63:0] SEED_MUL = {MIX_C, MIX_B, MIX_A, GOLD};
    localparam logic [3:0][5:0]  LANE_ROT = {6'd57, 6'd23, 6'd17, 6'd11};

    typedef enum logic [2:0] {
        PH_CALM,
        PH_SEND_GAPS,
        PH_RECV_STALL,
        PH_BOTH_GAPS,
        PH_PRESSURE
    } phase_t;

    typedef struct {
        logic        req_type;
        logic [63:0] seed;
        logic [31:0] total_length;
        logic [63:0] data_word;
        phase_t      phase;
    } hash_req_t;

    logic clk;
    logic rst_n;

    flah_in_if  request_if ();
    flah_out_if result_if ();

    four_lane_arx_hash u_top
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_if),
        .result  (result_if)
    );

    // Predictor state
    logic [63:0] mix_lane [4];
    logic [31:0] rem_bytes;
    logic [1:0]  word_pos;
    logic        msg_open;

    hash_req_t   req_queue [$];
    logic [63:0] owed_digests [$];
    phase_t      fill_phase;
    phase_t      live_phase;
    logic        in_fire;
    int          quiet_cycles;
    int          fail_count;
    int          press_left;
    bit          press_done;

    always #(HALF_PERIOD) clk = ~clk;

    function automatic logic [63:0] rol64(input logic [63:0] x, input logic [5:0] k);
        logic [127:0] d;
        d = {x, x} << k;
        return d[127:64];
    endfunction

    // Fold the lanes and run the xorshift-multiply finaliser
    function automatic logic [63:0] fold_digest();
        logic [63:0] h;
        h = mix_lane[0] ^ mix_lane[1] ^ mix_lane[2] ^ mix_lane[3];
        h ^= h >> 29;
        h *= MIX_A;
        h ^= h >> 31;
        h *= MIX_B;
        h ^= h >> 37;
        h *= GOLD;
        h ^= h >> 41;
        return h;
    endfunction

    // Advance the predicted state by one item; return 1 when a digest falls out
    function automatic bit absorb_item(input logic kind, input logic [63:0] seed,
                                       input logic [31:0] nbytes, input logic [63:0] word,
                                       output logic [63:0] digest);
        logic [63:0] base;
        logic [63:0] keep;
        logic [1:0]  nxt;
        int          i;
        digest = '0;
        if (kind == flah_pkg::REQ_START)
        begin
            base = seed ^ (64'(nbytes) * GOLD);
            for (i = 0; i < 4; i++)
            begin
                mix_lane[i] = base * SEED_MUL[i];
            end
            rem_bytes = nbytes;
            word_pos  = 2'd0;
            msg_open  = (nbytes != 0);
            if (nbytes == 0)
            begin
                digest = fold_digest();
                return 1'b1;
            end
            return 1'b0;
        end
        // Drop data while no message is open
        if (!msg_open)
        begin
            return 1'b0;
        end
        if (word_pos != 2'd0 || rem_bytes >= 32)
        begin
            // Whole block: each word feeds the next lane in turn
            nxt = word_pos + 2'd1;
            mix_lane[word_pos] = rol64((mix_lane[word_pos] ^ word) + mix_lane[nxt],
                                       LANE_ROT[word_pos]);
            word_pos  = nxt;
            rem_bytes = rem_bytes - 32'd8;
        end
        else
        begin
            // Words after the last block, and the zero-padded tail, go to lane one
            keep = (rem_bytes >= 8) ? '1
                 : (64'd1 << {rem_bytes[2:0], 3'b000}) - 64'd1;
            mix_lane[0] = rol64((mix_lane[0] ^ (word & keep)) + mix_lane[1], LANE_ROT[0]);
            rem_bytes = (rem_bytes >= 8) ? rem_bytes - 32'd8 : 32'd0;
        end
        if (rem_bytes == 0)
        begin
            msg_open = 1'b0;
            word_pos = 2'd0;
            digest   = fold_digest();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mostly short messages, a few several blocks long
    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 20)
            return $urandom_range(7, 0);
        else if (r < 70)
            return $urandom_range(64, 8);
        else if (r < 95)
            return $urandom_range(200, 65);
        return $urandom_range(520, 201);
    endfunction

    task automatic push_item(input logic kind, input logic [63:0] seed,
                             input logic [31:0] nbytes, input logic [63:0] word);
        hash_req_t it;
        it.req_type     = kind;
        it.seed         = seed;
        it.total_length = nbytes;
        it.data_word    = word;
        it.phase        = fill_phase;
        req_queue.push_back(it);
    endtask

    // Start item followed by exactly the words the length needs, random content
    task automatic push_message(input logic [63:0] seed, input int unsigned nbytes);
        int unsigned nwords;
        nwords = (nbytes + 7) / 8;
        push_item(flah_pkg::REQ_START, seed, nbytes, rand64());
        repeat (nwords)
        begin
            push_item(flah_pkg::REQ_DATA, rand64(), $urandom, rand64());
        end
    endtask

    task automatic fill_random(input phase_t ph, input int upto);
        int unsigned pick;
        fill_phase = ph;
        while (req_queue.size() < upto)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                push_message(rand64(), pick_len());
            end
            else if (pick < 80)
            begin
                // Well-formed message with stray words after its end
                push_message(rand64(), pick_len());
                repeat ($urandom_range(3, 1))
                begin
                    push_item(flah_pkg::REQ_DATA, rand64(), $urandom, rand64());
                end
            end
            else if (pick < 92)
            begin
                // Open a message of any length and leave it for the next start
                push_item(flah_pkg::REQ_START, rand64(), $urandom, rand64());
                repeat ($urandom_range(3, 0))
                begin
                    push_item(flah_pkg::REQ_DATA, rand64(), $urandom, rand64());
                end
            end
            else
            begin
                push_item(flah_pkg::REQ_DATA, rand64(), $urandom, rand64());
            end
        end
    endtask

    // Offer items from the queue; hold each one until it is taken
    always @(negedge clk)
    begin : drive_proc
        hash_req_t nxt;
        bit        offer;
        if (rst_n && (!request_if.valid || in_fire))
        begin
            offer = 1'b0;
            if (req_queue.size() != 0)
            begin
                case (req_queue[0].phase)
                    PH_SEND_GAPS: offer = ($urandom_range(99) >= 65);
                    PH_BOTH_GAPS: offer = ($urandom_range(99) >= 28);
                    default:      offer = 1'b1;
                endcase
            end
            if (offer)
            begin
                nxt = req_queue.pop_front();
                request_if.req_type     <= nxt.req_type;
                request_if.seed         <= nxt.seed;
                request_if.total_length <= nxt.total_length;
                request_if.data_word    <= nxt.data_word;
                live_phase              <= nxt.phase;
            end
            request_if.valid <= offer;
        end
    end

    // Drive ready: random stalls by phase, one long hold-off under pressure
    always @(negedge clk)
    begin : accept_proc
        logic rdy;
        if (!rst_n)
        begin
            rdy = 1'b0;
        end
        else if (press_left > 0)
        begin
            rdy = 1'b0;
            press_left--;
        end
        else if (live_phase == PH_PRESSURE && !press_done)
        begin
            press_done = 1'b1;
            press_left = PRESS_HOLD - 1;
            rdy = 1'b0;
        end
        else
        begin
            case (live_phase)
                PH_RECV_STALL: rdy = ($urandom_range(99) >= 65);
                PH_BOTH_GAPS:  rdy = ($urandom_range(99) >= 28);
                default:       rdy = 1'b1;
            endcase
        end
        result_if.ready <= rdy;
    end

    // Check delivered digests, predict from accepted items, watch for a hang
    always @(posedge clk)
    begin : check_proc
        logic [63:0] want;
        logic [63:0] dig;
        bit          any_fire;
        if (!rst_n)
        begin
            in_fire <= 1'b0;
        end
        else
        begin
            in_fire <= request_if.valid && request_if.ready;
            any_fire = (request_if.valid && request_if.ready)
                    || (result_if.valid && result_if.ready);
            if (result_if.valid && result_if.ready)
            begin
                if (owed_digests.size() == 0)
                begin
                    $error("digest: expected none, actual %h", result_if.digest);
                    fail_count++;
                end
                else
                begin
                    want = owed_digests.pop_front();
                    if (result_if.digest !== want)
                    begin
                        $error("digest: expected %h, actual %h", want, result_if.digest);
                        fail_count++;
                    end
                end
            end
            if (request_if.valid && request_if.ready)
            begin
                if (absorb_item(request_if.req_type, request_if.seed,
                                request_if.total_length, request_if.data_word, dig))
                begin
                    owed_digests.push_back(dig);
                end
            end
            quiet_cycles = any_fire ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        clk   = 1'b0;
        rst_n = 1'b0;
        request_if.valid        = 1'b0;
        request_if.req_type     = flah_pkg::REQ_START;
        request_if.seed         = '0;
        request_if.total_length = '0;
        request_if.data_word    = '0;
        result_if.ready         = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            mix_lane[i] = '0;
        end
        rem_bytes    = '0;
        word_pos     = '0;
        msg_open     = 1'b0;
        in_fire      = 1'b0;
        quiet_cycles = 0;
        fail_count   = 0;
        press_left   = 0;
        press_done   = 1'b0;
        live_phase   = PH_CALM;

        // Directed items, no idling
        fill_phase = PH_CALM;
        // zero-length messages at both seed extremes
        push_item(flah_pkg::REQ_START, '0, '0, '0);
        push_item(flah_pkg::REQ_START, '1, '0, '1);
        // data while idle
        push_item(flah_pkg::REQ_DATA, '1, '1, '1);
        // three-byte tail, bytes past the length set to be masked
        push_item(flah_pkg::REQ_START, '1, 32'd3, '0);
        push_item(flah_pkg::REQ_DATA, '0, '0, '1);
        // a single whole word, no block
        push_item(flah_pkg::REQ_START, '0, 32'd8, '0);
        push_item(flah_pkg::REQ_DATA, '0, '0, '0);
        // exactly one block
        push_item(flah_pkg::REQ_START, rand64(), 32'd32, '0);
        push_item(flah_pkg::REQ_DATA, '0, '0, '0);
        push_item(flah_pkg::REQ_DATA, '1, '1, '1);
        push_item(flah_pkg::REQ_DATA, rand64(), $urandom, rand64());
        push_item(flah_pkg::REQ_DATA, rand64(), $urandom, rand64());
        // longest length, abandoned by a new start
        push_item(flah_pkg::REQ_START, rand64(), '1, '0);
        push_item(flah_pkg::REQ_DATA, rand64(), $urandom, rand64());
        push_item(flah_pkg::REQ_DATA, rand64(), $urandom, rand64());
        push_item(flah_pkg::REQ_START, rand64(), 32'd7, '0);
        push_item(flah_pkg::REQ_DATA, rand64(), $urandom, rand64());
        // word after the message has completed
        push_item(flah_pkg::REQ_DATA, rand64(), $urandom, rand64());
        // block, whole word after it, then one tail byte
        push_message(rand64(), 41);

        // Random items over the idling phases, with a burst to fill the block
        fill_random(PH_CALM, 140);
        fill_random(PH_SEND_GAPS, 255);
        fill_random(PH_RECV_STALL, 370);
        fill_phase = PH_PRESSURE;
        repeat (14)
        begin
            push_message(rand64(), $urandom_range(8, 0));
        end
        fill_random(PH_BOTH_GAPS, 500);

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drain: all items taken, every owed digest delivered, then a quiet tail
        while (req_queue.size() != 0 || request_if.valid)
        begin
            @(negedge clk);
        end
        while (owed_digests.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (TAIL_CYCLES) @(negedge clk);

        if (owed_digests.size() != 0)
        begin
            $error("digest: expected %h, actual none (%0d outstanding)",
                   owed_digests[0], owed_digests.size());
            fail_count++;
        end
        if (fail_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> four_lane_arx_hash.f
src/flah_pkg.sv
src/flah_in_if.sv
src/flah_out_if.sv
src/flah_mul.sv
src/flah_datapath.sv
src/flah_ctrl.sv
src/four_lane_arx_hash.sv
dv/four_lane_arx_hash_tb.sv
